FILE: hdl/linked_queue_with_handle_delete_core_macros.svh
// Assertion macros for the linked queue core.
`ifndef LINKED_QUEUE_WITH_HANDLE_DELETE_CORE_MACROS_SVH
`define LINKED_QUEUE_WITH_HANDLE_DELETE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LQHD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LQHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/lqhd_pkg.sv
`default_nettype none

package lqhd_pkg;

   localparam int FUNC_W     = 2;
   localparam int PAYLOAD_W  = 32;
   localparam int HANDLE_W   = 4;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;

   // free slot search works on groups of in-use bits
   localparam int GROUP_SIZE = 16;
   localparam int GROUP_BITS = 4;

   localparam logic [FUNC_W-1:0] FUNC_ENQ = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEQ = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DEL = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [PAYLOAD_W-1:0] payload;
      logic [HANDLE_W-1:0]  handle;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [PAYLOAD_W-1:0] data_out;
      logic [HANDLE_W-1:0]  handle_out;
      logic [COUNT_W-1:0]   element_count;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic scan;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic scan_hit;
   } dp_sts_type;

endpackage

`default_nettype wire

FILE: hdl/lqhd_chan_if.sv
`default_nettype none

interface lqhd_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/lqhd_ctrl.sv
`default_nettype none

module lqhd_ctrl import lqhd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ctl_cmd_type      cmd,
   input  wire dp_sts_type  sts
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.exec    = 1'b0;
      cmd.scan    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            if (rsp_free) begin
               cmd.exec = 1'b1;
               state_in = sts.scan_needed ? S_SCAN : S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_hit) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      priority if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/lqhd_datapath.sv
`default_nettype none

module lqhd_datapath import lqhd_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int DATA_WIDTH  = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctl_cmd_type  cmd,
   output dp_sts_type        sts,
   input  wire req_type      req_data,
   output rsp_type           rsp_data
);

   localparam int IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int GROUPS = (QUEUE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_W  = GROUPS * GROUP_SIZE;
   localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

   // slot store and links
   logic [DATA_WIDTH-1:0] data_mem [QUEUE_DEPTH];
   logic [IDX_W-1:0]      next_mem [QUEUE_DEPTH];
   logic [IDX_W-1:0]      prev_mem [QUEUE_DEPTH];

   logic [DATA_WIDTH-1:0]  rd_data_ff;
   logic [IDX_W-1:0]       rd_next_ff;
   logic [IDX_W-1:0]       rd_prev_ff;
   logic [IDX_W-1:0]       rd_addr;

   logic [FUNC_W-1:0]      func_ff;
   logic [DATA_WIDTH-1:0]  payload_ff;
   logic [HANDLE_W-1:0]    handle_ff;

   logic [QUEUE_DEPTH-1:0] in_use_ff;
   logic [QUEUE_DEPTH-1:0] in_use_in;
   logic [IDX_W-1:0]       head_ff;
   logic [IDX_W-1:0]       head_in;
   logic [IDX_W-1:0]       tail_ff;
   logic [IDX_W-1:0]       tail_in;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       cnt_in;
   logic [IDX_W-1:0]       free_ff;
   logic [IDX_W-1:0]       free_in;
   logic [GRP_W-1:0]       scan_grp_ff;
   logic [GRP_W-1:0]       scan_grp_in;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;

   logic                   full;
   logic                   empty;
   logic                   found;
   logic [IDX_W-1:0]       hidx;
   logic                   is_head;
   logic                   is_tail;
   logic                   take;
   logic                   rel;
   logic [IDX_W-1:0]       rel_slot;
   logic                   scan_needed;

   logic                   d_we;
   logic                   n_we;
   logic [IDX_W-1:0]       n_wa;
   logic [IDX_W-1:0]       n_wd;
   logic                   p_we;
   logic [IDX_W-1:0]       p_wa;
   logic [IDX_W-1:0]       p_wd;

   logic [PAD_W-1:0]       used_pad;
   logic [GROUP_SIZE-1:0]  grp_bits;
   logic [GROUP_BITS-1:0]  scan_off;
   logic                   scan_hit;

   assign rd_addr = (req_data.func == FUNC_DEQ) ? head_ff : IDX_W'(req_data.handle);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req_data.func;
         payload_ff <= DATA_WIDTH'(req_data.payload);
         handle_ff  <= req_data.handle;
         rd_data_ff <= data_mem[rd_addr];
         rd_next_ff <= next_mem[rd_addr];
         rd_prev_ff <= prev_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && d_we) begin
         data_mem[free_ff] <= payload_ff;
      end
      if (cmd.exec && n_we) begin
         next_mem[n_wa] <= n_wd;
      end
      if (cmd.exec && p_we) begin
         prev_mem[p_wa] <= p_wd;
      end
   end

   assign full    = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign hidx    = IDX_W'(handle_ff);
   assign found   = (32'(handle_ff) < 32'(QUEUE_DEPTH)) && in_use_ff[hidx];
   assign is_head = (hidx == head_ff);
   assign is_tail = (hidx == tail_ff);

   always_comb begin
      rsp_in          = '0;
      rsp_in.status   = ST_OK;
      head_in         = head_ff;
      tail_in         = tail_ff;
      cnt_in          = cnt_ff;
      take            = 1'b0;
      rel             = 1'b0;
      rel_slot        = head_ff;
      d_we            = 1'b0;
      n_we            = 1'b0;
      n_wa            = tail_ff;
      n_wd            = free_ff;
      p_we            = 1'b0;
      p_wa            = free_ff;
      p_wd            = tail_ff;
      scan_needed     = 1'b0;
      unique case (func_ff)
         FUNC_ENQ: begin
            if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               take = 1'b1;
               d_we = 1'b1;
               if (empty) begin
                  head_in = free_ff;
               end else begin
                  n_we = 1'b1;
                  p_we = 1'b1;
               end
               tail_in           = free_ff;
               cnt_in            = cnt_ff + CNT_W'(1);
               rsp_in.handle_out = HANDLE_W'(free_ff);
               scan_needed       = (cnt_ff != CNT_W'(QUEUE_DEPTH - 1));
            end
         end
         FUNC_DEQ: begin
            if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               rsp_in.data_out = PAYLOAD_W'(rd_data_ff);
               if (cnt_ff > CNT_W'(1)) begin
                  head_in = rd_next_ff;
               end
               rel      = 1'b1;
               rel_slot = head_ff;
               cnt_in   = cnt_ff - CNT_W'(1);
            end
         end
         FUNC_DEL: begin
            priority if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (!found) begin
               rsp_in.status = ST_NOT_FOUND;
            end else begin
               rel      = 1'b1;
               rel_slot = hidx;
               cnt_in   = cnt_ff - CNT_W'(1);
               priority if (is_head && is_tail) begin
                  // sole entry, list becomes empty
               end else if (is_head) begin
                  head_in = rd_next_ff;
               end else if (is_tail) begin
                  tail_in = rd_prev_ff;
               end else begin
                  n_we = 1'b1;
                  n_wa = rd_prev_ff;
                  n_wd = rd_next_ff;
                  p_we = 1'b1;
                  p_wa = rd_next_ff;
                  p_wd = rd_prev_ff;
               end
            end
         end
         default: ;
      endcase
      rsp_in.element_count = COUNT_W'(cnt_in);
   end

   // lowest free slot: one group of in-use bits per cycle
   always_comb begin
      used_pad                  = '1;
      used_pad[QUEUE_DEPTH-1:0] = in_use_ff;
   end

   assign grp_bits = used_pad[scan_grp_ff * GROUP_SIZE +: GROUP_SIZE];

   always_comb begin
      scan_off = '0;
      scan_hit = 1'b0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (!grp_bits[i]) begin
            scan_off = GROUP_BITS'(i);
            scan_hit = 1'b1;
         end
      end
   end

   assign sts = '{scan_needed: scan_needed, scan_hit: scan_hit};

   always_comb begin
      in_use_in   = in_use_ff;
      free_in     = free_ff;
      scan_grp_in = scan_grp_ff;
      if (cmd.exec) begin
         if (take) begin
            in_use_in[free_ff] = 1'b1;
            scan_grp_in        = GRP_W'(free_ff >> GROUP_BITS);
         end
         if (rel) begin
            in_use_in[rel_slot] = 1'b0;
            if (full || (rel_slot < free_ff)) begin
               free_in = rel_slot;
            end
         end
      end else if (cmd.scan) begin
         if (scan_hit) begin
            free_in = IDX_W'({scan_grp_ff, scan_off});
         end else begin
            scan_grp_in = scan_grp_ff + GRP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff   <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         cnt_ff      <= '0;
         free_ff     <= '0;
         scan_grp_ff <= '0;
      end else begin
         in_use_ff   <= in_use_in;
         free_ff     <= free_in;
         scan_grp_ff <= scan_grp_in;
         if (cmd.exec) begin
            head_ff <= head_in;
            tail_ff <= tail_in;
            cnt_ff  <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/linked_queue_with_handle_delete_core.sv
// Channel   Dir  Transaction payload
// req_chan  in   func, payload, handle
// rsp_chan  out  status, data_out, handle_out, element_count
//
// Each request is captured on the accepting edge and executed in the update state,
// which registers the result; a successful enqueue that leaves a slot free then runs
// the free slot search over the 16-slot groups before the next request is accepted.
// A waiting result holds the block in its update cycle until the result is taken.
// Synchronous reset clears the in-use bits, head, tail and count and holds req ready
// low; data and link memories are not cleared and need no pass after reset.
`default_nettype none

module linked_queue_with_handle_delete_core import lqhd_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int DATA_WIDTH  = 32
) (
   input wire logic   clock,
   input wire logic   reset,
   lqhd_chan_if.sink   req_chan,
   lqhd_chan_if.source rsp_chan
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   lqhd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   lqhd_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_chan.data),
      .rsp_data (rsp_chan.data)
   );

endmodule

`default_nettype wire

FILE: hdl/lqhd_checker.sv
`default_nettype none

`include "linked_queue_with_handle_delete_core_macros.svh"

module lqhd_checker import lqhd_pkg::*; #(
   parameter int QUEUE_DEPTH = 16
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   `LQHD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")

   `LQHD_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "transaction accepted while previous one in progress")

   `LQHD_ASSERT_SAME(a_empty_count, clock, reset, rsp_valid && (rsp_data.status == ST_EMPTY), rsp_data.element_count == '0, "empty status with non-zero count")

   `LQHD_ASSERT_SAME(a_full_count, clock, reset, rsp_valid && (rsp_data.status == ST_FULL), rsp_data.element_count == COUNT_W'(QUEUE_DEPTH), "full status with count below depth")

endmodule

bind linked_queue_with_handle_delete_core lqhd_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_lqhd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

`default_nettype wire
